FILE: hdl/xbr_pkg.sv
`default_nettype none

package xbr_pkg;

    localparam int BOUND_W = 32;
    localparam int VALUE_W = 31;
    localparam int WORD_W = 64;

    localparam logic [63:0] GOLDEN_STEP = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] MIX_MUL_A = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX_MUL_B = 64'h94d049bb133111eb;
    localparam logic [63:0] SEED_RESET = 64'd42;

    localparam int ROT_LATE = 45;
    localparam int ROT_OUT = 7;
    localparam int SHIFT_T = 17;
    localparam int TOP_SHIFT = 33;

    localparam logic [1:0] OP_RESEED = 2'd0;
    localparam logic [1:0] OP_DRAW = 2'd1;
    localparam logic [1:0] OP_ZERO_BOUND = 2'd2;

    typedef struct packed {
        logic [1:0]         op;
        logic [BOUND_W-1:0] bound;
    } xbr_item_t;

endpackage

`default_nettype wire

FILE: hdl/xbr_front.sv
`default_nettype none

module xbr_front (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic                      s_kind,
    input  wire logic [xbr_pkg::BOUND_W-1:0] s_bound,
    output logic                           push_valid,
    output xbr_pkg::xbr_item_t             push_item,
    input  wire logic                      queue_full
);

    logic               valid_reg;
    logic               valid_next;
    xbr_pkg::xbr_item_t item_reg;
    xbr_pkg::xbr_item_t item_next;
    logic               push_done;
    logic               accept;

    assign push_done = valid_reg && !queue_full;
    assign s_ready = !valid_reg || !queue_full;
    assign accept = s_valid && s_ready;
    assign push_valid = valid_reg;
    assign push_item = item_reg;

    always_comb begin
        valid_next = valid_reg;
        item_next = item_reg;
        if (push_done) begin
            valid_next = 1'b0;
        end
        if (accept) begin
            valid_next = 1'b1;
            item_next.bound = s_bound;
            if (!s_kind) begin
                item_next.op = xbr_pkg::OP_RESEED;
            end else if (s_bound == '0) begin
                item_next.op = xbr_pkg::OP_ZERO_BOUND;
            end else begin
                item_next.op = xbr_pkg::OP_DRAW;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        item_reg <= item_next;
    end

endmodule

`default_nettype wire

FILE: hdl/xbr_queue.sv
`default_nettype none

module xbr_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               push,
    input  wire xbr_pkg::xbr_item_t push_item,
    output logic                    full,
    input  wire logic               pop,
    output xbr_pkg::xbr_item_t      head_item,
    output logic                    empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    xbr_pkg::xbr_item_t mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               do_push;
    logic               do_pop;

    assign full = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop = pop && !empty;
    assign head_item = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/xbr_back.sv
`default_nettype none

module xbr_back (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        cfg_wr_en,
    input  wire logic [63:0]                 cfg_wr_data,
    input  wire logic                        queue_empty,
    input  wire xbr_pkg::xbr_item_t          head_item,
    output logic                             pop,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [xbr_pkg::VALUE_W-1:0]      m_value,
    output logic                             m_bad_bound
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_MIX_SEED = 4'd1;
    localparam logic [3:0] ST_MUL = 4'd2;
    localparam logic [3:0] ST_MIX_MID = 4'd3;
    localparam logic [3:0] ST_STORE = 4'd4;
    localparam logic [3:0] ST_GEN = 4'd5;
    localparam logic [3:0] ST_SCRAMBLE = 4'd6;
    localparam logic [3:0] ST_DIV = 4'd7;
    localparam logic [3:0] ST_DONE = 4'd8;

    localparam logic [1:0] MUL_LAST = 2'd2;
    localparam logic [1:0] WORD_LAST = 2'd3;
    localparam int DIV_CNT_W = $clog2(xbr_pkg::VALUE_W);
    localparam logic [DIV_CNT_W-1:0] DIV_START = DIV_CNT_W'(xbr_pkg::VALUE_W - 1);

    logic [3:0]  state_reg, state_next;
    logic [63:0] seed_reg, seed_next;
    logic [63:0] gen_reg [4];
    logic [63:0] gen_next [4];
    logic [63:0] mix_reg, mix_next;
    logic [63:0] mul_a_reg, mul_a_next;
    logic [63:0] acc_reg, acc_next;
    logic [1:0]  phase_reg, phase_next;
    logic        mul_sel_reg, mul_sel_next;
    logic [1:0]  word_reg, word_next;
    logic [63:0] scr_reg, scr_next;
    logic [31:0] bound_reg, bound_next;
    logic [xbr_pkg::VALUE_W-1:0] quot_reg, quot_next;
    logic [32:0] rem_reg, rem_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic [xbr_pkg::VALUE_W-1:0] res_value_reg, res_value_next;
    logic        res_bad_reg, res_bad_next;
    logic        m_valid_reg, m_valid_next;
    logic [xbr_pkg::VALUE_W-1:0] m_value_reg, m_value_next;
    logic        m_bad_reg, m_bad_next;

    logic [63:0] mul_const;
    logic [31:0] mul_x;
    logic [31:0] mul_y;
    logic [63:0] mul_prod;
    logic [63:0] seed_sum;
    logic [63:0] w1_times5;
    logic [63:0] scr_times9;
    logic [63:0] t_word;
    logic [63:0] n0, n1, n2, n3;
    logic [32:0] trial;

    assign mul_const = mul_sel_reg ? xbr_pkg::MIX_MUL_B : xbr_pkg::MIX_MUL_A;
    assign mul_x = (phase_reg == 2'd1) ? mul_a_reg[63:32] : mul_a_reg[31:0];
    assign mul_y = (phase_reg == MUL_LAST) ? mul_const[63:32] : mul_const[31:0];
    assign mul_prod = {32'd0, mul_x} * {32'd0, mul_y};

    assign seed_sum = mix_reg + xbr_pkg::GOLDEN_STEP;
    assign w1_times5 = gen_reg[1] + {gen_reg[1][61:0], 2'b00};
    assign scr_times9 = scr_reg + {scr_reg[60:0], 3'b000};
    assign t_word = gen_reg[1] << xbr_pkg::SHIFT_T;

    assign n2 = gen_reg[2] ^ gen_reg[0];
    assign n3 = gen_reg[3] ^ gen_reg[1];
    assign n1 = gen_reg[1] ^ n2;
    assign n0 = gen_reg[0] ^ n3;

    assign trial = {rem_reg[31:0], quot_reg[xbr_pkg::VALUE_W-1]};

    assign pop = (state_reg == ST_IDLE) && !queue_empty;
    assign m_valid = m_valid_reg;
    assign m_value = m_value_reg;
    assign m_bad_bound = m_bad_reg;

    always_comb begin
        state_next = state_reg;
        seed_next = cfg_wr_en ? cfg_wr_data : seed_reg;
        for (int k = 0; k < 4; k++) begin
            gen_next[k] = gen_reg[k];
        end
        mix_next = mix_reg;
        mul_a_next = mul_a_reg;
        acc_next = acc_reg;
        phase_next = phase_reg;
        mul_sel_next = mul_sel_reg;
        word_next = word_reg;
        scr_next = scr_reg;
        bound_next = bound_reg;
        quot_next = quot_reg;
        rem_next = rem_reg;
        div_cnt_next = div_cnt_reg;
        res_value_next = res_value_reg;
        res_bad_next = res_bad_reg;
        m_valid_next = m_valid_reg;
        m_value_next = m_value_reg;
        m_bad_next = m_bad_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (!queue_empty) begin
                    bound_next = head_item.bound;
                    if (head_item.op == xbr_pkg::OP_RESEED) begin
                        mix_next = seed_reg;
                        word_next = '0;
                        state_next = ST_MIX_SEED;
                    end else begin
                        res_bad_next = (head_item.op == xbr_pkg::OP_ZERO_BOUND);
                        state_next = ST_GEN;
                    end
                end
            end
            ST_MIX_SEED: begin
                mix_next = seed_sum;
                mul_a_next = seed_sum ^ (seed_sum >> 30);
                mul_sel_next = 1'b0;
                phase_next = '0;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                if (phase_reg == '0) begin
                    acc_next = mul_prod;
                end else begin
                    acc_next = acc_reg + {mul_prod[31:0], 32'd0};
                end
                phase_next = phase_reg + 1'b1;
                if (phase_reg == MUL_LAST) begin
                    state_next = mul_sel_reg ? ST_STORE : ST_MIX_MID;
                end
            end
            ST_MIX_MID: begin
                mul_a_next = acc_reg ^ (acc_reg >> 27);
                mul_sel_next = 1'b1;
                phase_next = '0;
                state_next = ST_MUL;
            end
            ST_STORE: begin
                gen_next[word_reg] = acc_reg ^ (acc_reg >> 31);
                if (word_reg == WORD_LAST) begin
                    res_value_next = '0;
                    res_bad_next = 1'b0;
                    state_next = ST_DONE;
                end else begin
                    word_next = word_reg + 1'b1;
                    state_next = ST_MIX_SEED;
                end
            end
            ST_GEN: begin
                scr_next = {w1_times5[63-xbr_pkg::ROT_OUT:0],
                            w1_times5[63:64-xbr_pkg::ROT_OUT]};
                gen_next[0] = n0;
                gen_next[1] = n1;
                gen_next[2] = n2 ^ t_word;
                gen_next[3] = {n3[63-xbr_pkg::ROT_LATE:0], n3[63:64-xbr_pkg::ROT_LATE]};
                state_next = ST_SCRAMBLE;
            end
            ST_SCRAMBLE: begin
                quot_next = scr_times9[63:xbr_pkg::TOP_SHIFT];
                rem_next = '0;
                div_cnt_next = DIV_START;
                if (res_bad_reg) begin
                    res_value_next = '0;
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (trial >= {1'b0, bound_reg}) begin
                    rem_next = trial - {1'b0, bound_reg};
                end else begin
                    rem_next = trial;
                end
                quot_next = {quot_reg[xbr_pkg::VALUE_W-2:0], 1'b0};
                div_cnt_next = div_cnt_reg - 1'b1;
                if (div_cnt_reg == '0) begin
                    res_value_next = rem_next[xbr_pkg::VALUE_W-1:0];
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_value_next = res_value_reg;
                    m_bad_next = res_bad_reg;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            seed_reg <= xbr_pkg::SEED_RESET;
            for (int k = 0; k < 4; k++) begin
                gen_reg[k] <= '0;
            end
            m_valid_reg <= 1'b0;
            res_bad_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            seed_reg <= seed_next;
            for (int k = 0; k < 4; k++) begin
                gen_reg[k] <= gen_next[k];
            end
            m_valid_reg <= m_valid_next;
            res_bad_reg <= res_bad_next;
        end
        mix_reg <= mix_next;
        mul_a_reg <= mul_a_next;
        acc_reg <= acc_next;
        phase_reg <= phase_next;
        mul_sel_reg <= mul_sel_next;
        word_reg <= word_next;
        scr_reg <= scr_next;
        bound_reg <= bound_next;
        quot_reg <= quot_next;
        rem_reg <= rem_next;
        div_cnt_reg <= div_cnt_next;
        res_value_reg <= res_value_next;
        m_value_reg <= m_value_next;
        m_bad_reg <= m_bad_next;
    end

endmodule

`default_nettype wire

FILE: hdl/xoshiro_bounded_random.sv
// A draw goes from the queue head through the generator step, the scrambler and the
// 31-step restoring remainder unit to the result register; a zero bound skips it.
// A reseed runs four splitmix64 rounds of two 64-bit products,
// each built from three 32x32 partial products on one shared multiplier.
// Accepted items are registered in a front stage; one item is processed at a time.
// Synchronous active-low reset clears the generator state to zero and the seed to 42.
`default_nettype none

module xoshiro_bounded_random #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic [63:0]                   cfg_wr_data,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          s_kind,
    input  wire logic [xbr_pkg::BOUND_W-1:0]   s_bound,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [xbr_pkg::VALUE_W-1:0]        m_value,
    output logic                               m_bad_bound
);

    logic               push_valid;
    xbr_pkg::xbr_item_t push_item;
    logic               queue_full;
    logic               queue_empty;
    logic               pop;
    xbr_pkg::xbr_item_t head_item;

    xbr_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_kind     (s_kind),
        .s_bound    (s_bound),
        .push_valid (push_valid),
        .push_item  (push_item),
        .queue_full (queue_full)
    );

    xbr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push_valid),
        .push_item (push_item),
        .full      (queue_full),
        .pop       (pop),
        .head_item (head_item),
        .empty     (queue_empty)
    );

    xbr_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .queue_empty (queue_empty),
        .head_item   (head_item),
        .pop         (pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_value     (m_value),
        .m_bad_bound (m_bad_bound)
    );

endmodule

`default_nettype wire

FILE: test/tb_xoshiro_bounded_random.sv
`timescale 1ns / 1ps

typedef enum logic {
    KIND_RESEED = 1'b0,
    KIND_DRAW   = 1'b1
} item_kind_t;

typedef struct packed {
    logic [xbr_pkg::VALUE_W-1:0] value;
    logic                        bad_bound;
} draw_result_t;

class bounded_draw_tracker;
    logic [xbr_pkg::WORD_W-1:0] gen_word [4];
    logic [xbr_pkg::WORD_W-1:0] seed;
    draw_result_t               expected_draws [$];
    int                         errors;
    int                         reseeds;
    int                         draws;
    int                         zero_bounds;
    int                         seed_writes;

    function new();
        seed = xbr_pkg::SEED_RESET;
        foreach (gen_word[i]) gen_word[i] = '0;
        errors = 0;
        reseeds = 0;
        draws = 0;
        zero_bounds = 0;
        seed_writes = 0;
    endfunction

    function logic [63:0] rotl(input logic [63:0] v, input int r);
        return (v << r) | (v >> (64 - r));
    endfunction

    function void set_seed(input logic [63:0] v);
        seed = v;
        seed_writes++;
    endfunction

    function void expand_seed();
        logic [63:0] s;
        logic [63:0] z;
        s = seed;
        for (int i = 0; i < 4; i++) begin
            s = s + xbr_pkg::GOLDEN_STEP;
            z = s;
            z = (z ^ (z >> 30)) * xbr_pkg::MIX_MUL_A;
            z = (z ^ (z >> 27)) * xbr_pkg::MIX_MUL_B;
            gen_word[i] = z ^ (z >> 31);
        end
    endfunction

    function logic [63:0] step_generator();
        logic [63:0] times5;
        logic [63:0] scrambled;
        logic [63:0] shifted;
        times5 = gen_word[1] * 64'd5;
        scrambled = rotl(times5, xbr_pkg::ROT_OUT) * 64'd9;
        shifted = gen_word[1] << xbr_pkg::SHIFT_T;
        gen_word[2] = gen_word[2] ^ gen_word[0];
        gen_word[3] = gen_word[3] ^ gen_word[1];
        gen_word[1] = gen_word[1] ^ gen_word[2];
        gen_word[0] = gen_word[0] ^ gen_word[3];
        gen_word[2] = gen_word[2] ^ shifted;
        gen_word[3] = rotl(gen_word[3], xbr_pkg::ROT_LATE);
        return scrambled;
    endfunction

    function void note_item(input item_kind_t kind, input logic [31:0] bound);
        draw_result_t r;
        logic [63:0]  top;
        r = '0;
        if (kind == KIND_RESEED) begin
            expand_seed();
            reseeds++;
        end else begin
            top = step_generator() >> xbr_pkg::TOP_SHIFT;
            draws++;
            if (bound == 32'd0) begin
                r.bad_bound = 1'b1;
                zero_bounds++;
            end else begin
                r.value = xbr_pkg::VALUE_W'(top % {32'd0, bound});
            end
        end
        expected_draws.push_back(r);
    endfunction

    function void check_result(input logic [xbr_pkg::VALUE_W-1:0] value,
                               input logic bad_bound);
        draw_result_t e;
        if (expected_draws.size() == 0) begin
            $error("result with no item outstanding: value %0d bad_bound %0d",
                   value, bad_bound);
            errors++;
            return;
        end
        e = expected_draws.pop_front();
        if (value !== e.value) begin
            $error("value mismatch: expected %0d, actual %0d", e.value, value);
            errors++;
        end
        if (bad_bound !== e.bad_bound) begin
            $error("bad_bound mismatch: expected %0d, actual %0d", e.bad_bound, bad_bound);
            errors++;
        end
    endfunction

    function int pending();
        return expected_draws.size();
    endfunction
endclass

module tb_xoshiro_bounded_random;

    localparam int CYCLE_LIMIT = 400000;

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          cfg_wr_en = 1'b0;
    logic [63:0]                   cfg_wr_data = '0;
    logic                          s_valid = 1'b0;
    logic                          s_ready;
    logic                          s_kind = 1'b0;
    logic [xbr_pkg::BOUND_W-1:0]   s_bound = '0;
    logic                          m_valid;
    logic                          m_ready = 1'b0;
    logic [xbr_pkg::VALUE_W-1:0]   m_value;
    logic                          m_bad_bound;

    bit                            sender_idle = 1'b0;
    bit                            receiver_idle = 1'b0;
    int unsigned                   cycle_count = 0;
    bounded_draw_tracker           tracker;

    xoshiro_bounded_random uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_kind      (s_kind),
        .s_bound     (s_bound),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_value     (m_value),
        .m_bad_bound (m_bad_bound)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic send_item(input item_kind_t kind, input logic [31:0] bound);
        int unsigned gap;
        gap = sender_idle ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_kind  <= kind;
        s_bound <= bound;
        do @(posedge aclk); while (!s_ready);
        tracker.note_item(kind, bound);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_seed(input logic [63:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        tracker.set_seed(v);
    endtask

    function automatic logic [31:0] pick_bound();
        case ($urandom_range(0, 9))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2, 3: return $urandom_range(1, 16);
            4: return 32'd1 << $urandom_range(0, 31);
            5: return $urandom_range(1, 32'h7FFF_FFFF);
            default: return $urandom;
        endcase
    endfunction

    initial begin
        int unsigned stall;
        wait (aresetn == 1'b1);
        forever begin
            stall = receiver_idle ? $urandom_range(0, 4) : 0;
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            tracker.check_result(m_value, m_bad_bound);
        end
    end

    initial begin
        logic [63:0] seed;
        tracker = new();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // The generator state is all zeros until the first reseed.
        send_item(KIND_DRAW, 32'hFFFF_FFFF);
        send_item(KIND_DRAW, 32'd0);
        send_item(KIND_DRAW, 32'd1);

        sender_idle = 1'b1;
        receiver_idle = 1'b1;
        send_item(KIND_RESEED, 32'hFFFF_FFFF);
        send_item(KIND_RESEED, 32'd0);
        send_item(KIND_DRAW, 32'hFFFF_FFFF);
        send_item(KIND_DRAW, 32'h8000_0000);
        send_item(KIND_DRAW, 32'h7FFF_FFFF);
        send_item(KIND_DRAW, 32'd0);
        send_item(KIND_DRAW, 32'd1);
        send_item(KIND_DRAW, 32'd2);
        send_item(KIND_DRAW, 32'd3);
        send_item(KIND_DRAW, 32'd10);

        wait_drained();
        write_seed(64'd0);
        send_item(KIND_RESEED, 32'd0);
        send_item(KIND_DRAW, 32'hFFFF_FFFF);
        send_item(KIND_DRAW, 32'd0);
        send_item(KIND_DRAW, 32'd7);

        wait_drained();
        write_seed(64'hFFFF_FFFF_FFFF_FFFF);
        send_item(KIND_RESEED, 32'd0);
        send_item(KIND_DRAW, 32'hFFFF_FFFF);
        send_item(KIND_DRAW, 32'd1000);

        for (int phase = 0; phase < 12; phase++) begin
            wait_drained();
            case (phase)
                4: seed = 64'hFFFF_FFFF_FFFF_FFFF;
                8: seed = 64'd0;
                default: seed = {$urandom, $urandom};
            endcase
            write_seed(seed);
            sender_idle = ($urandom_range(0, 2) != 0);
            receiver_idle = ($urandom_range(0, 2) != 0);
            send_item(KIND_RESEED, $urandom);
            repeat (144) begin
                if ($urandom_range(0, 29) == 0) begin
                    send_item(KIND_RESEED, $urandom);
                end else begin
                    send_item(KIND_DRAW, pick_bound());
                end
            end
        end

        wait_drained();
        repeat (40) @(posedge aclk);
        if (tracker.pending() != 0) begin
            $error("%0d expected results never arrived", tracker.pending());
            tracker.errors++;
        end

        $display("Covered %0d reseeds and %0d draws, %0d of them with a zero bound,",
                 tracker.reseeds, tracker.draws, tracker.zero_bounds);
        $display("across %0d seed register writes with random stalls on both sides.",
                 tracker.seed_writes);
        if (tracker.errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

FILE: sim.f
hdl/xbr_pkg.sv
hdl/xbr_front.sv
hdl/xbr_queue.sv
hdl/xbr_back.sv
hdl/xoshiro_bounded_random.sv
test/tb_xoshiro_bounded_random.sv
